// ===== rtl/tpc_pkg.sv =====
`default_nettype none

package tpc_pkg;

    localparam int MAP_ENTRIES = 4096;
    localparam int SHAPE_COUNT = 26;
    localparam int MAP_ADDR_W  = $clog2(MAP_ENTRIES);

    localparam int SHAPE_W  = 5;
    localparam int PIX_W    = 11;
    localparam int TILE_W   = 7;
    localparam int STRIDE_W = 7;
    localparam int ROW_W    = 4;
    localparam int MASK_W   = 16;
    localparam int COORD_W  = 16;
    localparam int EXT_W    = 18;
    localparam int LIN_W    = TILE_W + STRIDE_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W = 72;
    localparam int OUT_DATA_W = 8;
    localparam int ROM_SHAPES = 22;

    localparam logic [ROW_W-1:0]  LAST_ROW   = 4'hF;
    localparam logic [MASK_W-1:0] FULL_MASK  = 16'hFFFF;
    localparam logic [MASK_W-1:0] RIGHT_MASK = 16'h7FFF;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILES_ROW   = 2'd2;

    localparam logic [PIX_W-1:0]    GRID_WIDTH_RST  = 11'd1024;
    localparam logic [PIX_W-1:0]    GRID_HEIGHT_RST = 11'd1024;
    localparam logic [STRIDE_W-1:0] TILES_ROW_RST   = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLIP,
        ST_ADDR,
        ST_EVAL,
        ST_DONE
    } tpc_state_t;

    // packed so that map_address sits in the lowest bits
    typedef struct packed {
        logic              pad;
        logic [PIX_W-1:0]  rect_height;
        logic [PIX_W-1:0]  rect_width;
        logic [COORD_W-1:0] rect_y;
        logic [COORD_W-1:0] rect_x;
        logic [SHAPE_W-1:0] shape_id;
        logic [MAP_ADDR_W-1:0] map_address;
    } in_data_t;

    typedef struct packed {
        logic load;
        logic write;
        logic clip;
        logic read;
        logic step;
        logic res_load;
        logic res_hit;
    } tpc_cmd_t;

    typedef struct packed {
        logic empty;
        logic tile_hit;
        logic tile_last;
    } tpc_sts_t;

    localparam logic [MASK_W-1:0] SHAPE_ROM [ROM_SHAPES][16] = '{
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        '{16'h0001, 16'h0003, 16'h0007, 16'h000F, 16'h001F, 16'h003F, 16'h007F, 16'h00FF,
          16'h01FF, 16'h03FF, 16'h07FF, 16'h0FFF, 16'h1FFF, 16'h3FFF, 16'h7FFF, 16'hFFFF},
        '{16'hFFFF, 16'h7FFF, 16'h3FFF, 16'h1FFF, 16'h0FFF, 16'h07FF, 16'h03FF, 16'h01FF,
          16'h00FF, 16'h007F, 16'h003F, 16'h001F, 16'h000F, 16'h0007, 16'h0003, 16'h0001},
        '{16'h8000, 16'hC000, 16'hE000, 16'hF000, 16'hF800, 16'hFC00, 16'hFE00, 16'hFF00,
          16'hFF80, 16'hFFC0, 16'hFFE0, 16'hFFF0, 16'hFFF8, 16'hFFFC, 16'hFFFE, 16'hFFFF},
        '{16'hFFFF, 16'hFFFE, 16'hFFFC, 16'hFFF8, 16'hFFF0, 16'hFFE0, 16'hFFC0, 16'hFF80,
          16'hFF00, 16'hFE00, 16'hFC00, 16'hF800, 16'hF000, 16'hE000, 16'hC000, 16'h8000},
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          16'h0003, 16'h000F, 16'h003F, 16'h00FF, 16'h03FF, 16'h0FFF, 16'h3FFF, 16'hFFFF},
        '{16'hFFFF, 16'h3FFF, 16'h0FFF, 16'h03FF, 16'h00FF, 16'h003F, 16'h000F, 16'h0003,
          16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          16'hC000, 16'hF000, 16'hFC00, 16'hFF00, 16'hFFC0, 16'hFFF0, 16'hFFFC, 16'hFFFF},
        '{16'hFFFF, 16'hFFFC, 16'hFFF0, 16'hFFC0, 16'hFF00, 16'hFC00, 16'hF000, 16'hC000,
          16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'h0001, 16'h0001, 16'h0003, 16'h0003, 16'h0007, 16'h0007, 16'h000F, 16'h000F,
          16'h001F, 16'h001F, 16'h003F, 16'h003F, 16'h007F, 16'h007F, 16'h00FF, 16'h00FF},
        '{16'h00FF, 16'h00FF, 16'h007F, 16'h007F, 16'h003F, 16'h003F, 16'h001F, 16'h001F,
          16'h000F, 16'h000F, 16'h0007, 16'h0007, 16'h0003, 16'h0003, 16'h0001, 16'h0001},
        '{16'h8000, 16'h8000, 16'hC000, 16'hC000, 16'hE000, 16'hE000, 16'hF000, 16'hF000,
          16'hF800, 16'hF800, 16'hFC00, 16'hFC00, 16'hFE00, 16'hFE00, 16'hFF00, 16'hFF00},
        '{16'hFF00, 16'hFF00, 16'hFE00, 16'hFE00, 16'hFC00, 16'hFC00, 16'hF800, 16'hF800,
          16'hF000, 16'hF000, 16'hE000, 16'hE000, 16'hC000, 16'hC000, 16'h8000, 16'h8000},
        '{16'h0003, 16'h000F, 16'h003F, 16'h00FF, 16'h03FF, 16'h0FFF, 16'h3FFF, 16'hFFFF,
          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          16'hFFFF, 16'h3FFF, 16'h0FFF, 16'h03FF, 16'h00FF, 16'h003F, 16'h000F, 16'h0003},
        '{16'hC000, 16'hF000, 16'hFC00, 16'hFF00, 16'hFFC0, 16'hFFF0, 16'hFFFC, 16'hFFFF,
          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          16'hFFFF, 16'hFFFC, 16'hFFF0, 16'hFFC0, 16'hFF00, 16'hFC00, 16'hF000, 16'hC000},
        '{16'h01FF, 16'h01FF, 16'h03FF, 16'h03FF, 16'h07FF, 16'h07FF, 16'h0FFF, 16'h0FFF,
          16'h1FFF, 16'h1FFF, 16'h3FFF, 16'h3FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF},
        '{16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h3FFF, 16'h3FFF, 16'h1FFF, 16'h1FFF,
          16'h0FFF, 16'h0FFF, 16'h07FF, 16'h07FF, 16'h03FF, 16'h03FF, 16'h01FF, 16'h01FF},
        '{16'hFF80, 16'hFF80, 16'hFFC0, 16'hFFC0, 16'hFFE0, 16'hFFE0, 16'hFFF0, 16'hFFF0,
          16'hFFF8, 16'hFFF8, 16'hFFFC, 16'hFFFC, 16'hFFFE, 16'hFFFE, 16'hFFFF, 16'hFFFF},
        '{16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFE, 16'hFFFC, 16'hFFFC, 16'hFFF8, 16'hFFF8,
          16'hFFF0, 16'hFFF0, 16'hFFE0, 16'hFFE0, 16'hFFC0, 16'hFFC0, 16'hFF80, 16'hFF80}
    };

    // shapes without a mask set, and those past the shape count, are empty
    function automatic logic [MASK_W-1:0] row_mask(input logic [SHAPE_W-1:0] shape,
                                                   input logic [ROW_W-1:0] row);
        logic [MASK_W-1:0] mask;
        mask = '0;
        if (int'(shape) < SHAPE_COUNT && int'(shape) < ROM_SHAPES)
        begin
            mask = SHAPE_ROM[shape][row];
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tpc_ctrl.sv =====
`default_nettype none

module tpc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    input  wire logic             s_opcode,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output tpc_pkg::tpc_cmd_t     cmd,
    input  wire tpc_pkg::tpc_sts_t sts
);

    tpc_pkg::tpc_state_t state_reg;
    tpc_pkg::tpc_state_t state_next;
    logic res_hit_reg;
    logic res_hit_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic in_xfer;
    logic out_free;

    assign in_xfer  = s_tvalid && (state_reg == tpc_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tpc_pkg::ST_IDLE;
            res_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_hit_reg   <= res_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        res_hit_next = res_hit_reg;
        unique case (state_reg)
            tpc_pkg::ST_IDLE:
            begin
                if (in_xfer && s_opcode == tpc_pkg::OP_QUERY)
                begin
                    state_next = tpc_pkg::ST_CLIP;
                end
            end
            tpc_pkg::ST_CLIP:
            begin
                state_next = tpc_pkg::ST_ADDR;
            end
            tpc_pkg::ST_ADDR:
            begin
                if (sts.empty)
                begin
                    state_next   = tpc_pkg::ST_DONE;
                    res_hit_next = 1'b0;
                end
                else
                begin
                    state_next = tpc_pkg::ST_EVAL;
                end
            end
            tpc_pkg::ST_EVAL:
            begin
                if (sts.tile_hit || sts.tile_last)
                begin
                    state_next   = tpc_pkg::ST_DONE;
                    res_hit_next = sts.tile_hit;
                end
                else
                begin
                    state_next = tpc_pkg::ST_ADDR;
                end
            end
            tpc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = tpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tpc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.load     = in_xfer;
        cmd.write    = in_xfer && (s_opcode == tpc_pkg::OP_WRITE);
        cmd.res_hit  = res_hit_reg;
        unique case (state_reg)
            tpc_pkg::ST_IDLE: ;
            tpc_pkg::ST_CLIP:
            begin
                cmd.clip = 1'b1;
            end
            tpc_pkg::ST_ADDR:
            begin
                cmd.read = !sts.empty;
            end
            tpc_pkg::ST_EVAL:
            begin
                cmd.step = !sts.tile_hit && !sts.tile_last;
            end
            tpc_pkg::ST_DONE:
            begin
                cmd.res_load = out_free;
            end
            default: ;
        endcase
    end

    assign out_valid_next = cmd.res_load || (out_valid_reg && !m_tready);
    assign s_tready       = (state_reg == tpc_pkg::ST_IDLE);
    assign m_tvalid       = out_valid_reg;

    // a tile may only be evaluated in the cycle after its map read
    a_eval_after_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tpc_pkg::ST_EVAL) |-> ($past(state_reg) == tpc_pkg::ST_ADDR))
        else $error("tile evaluated without a map read");

    a_addr_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tpc_pkg::ST_ADDR) |->
        ($past(state_reg) == tpc_pkg::ST_CLIP || $past(state_reg) == tpc_pkg::ST_EVAL))
        else $error("tile walk entered from a wrong state");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == tpc_pkg::ST_DONE))
        else $error("result raised outside completion");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tpc_pkg::ST_CLIP) |-> ($past(s_tvalid) && $past(s_opcode)))
        else $error("query started without an input transfer");

endmodule

`default_nettype wire

// ===== rtl/tpc_dp.sv =====
`default_nettype none

module tpc_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [tpc_pkg::IN_DATA_W-1:0]       s_tdata,
    input  wire logic                                cfg_valid,
    input  wire logic [tpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [tpc_pkg::PIX_W-1:0]           cfg_data,
    input  wire tpc_pkg::tpc_cmd_t                   cmd,
    output tpc_pkg::tpc_sts_t                        sts,
    output logic                                     hit
);

    tpc_pkg::in_data_t in_fields;

    logic [tpc_pkg::PIX_W-1:0]    grid_w_reg;
    logic [tpc_pkg::PIX_W-1:0]    grid_h_reg;
    logic [tpc_pkg::STRIDE_W-1:0] stride_reg;

    logic [tpc_pkg::COORD_W-1:0]  rx_reg;
    logic [tpc_pkg::COORD_W-1:0]  ry_reg;
    logic [tpc_pkg::PIX_W-1:0]    rw_reg;
    logic [tpc_pkg::PIX_W-1:0]    rh_reg;

    logic [tpc_pkg::PIX_W-1:0]    px0_reg;
    logic [tpc_pkg::PIX_W-1:0]    py0_reg;
    logic [tpc_pkg::PIX_W-1:0]    px1_reg;
    logic [tpc_pkg::PIX_W-1:0]    py1_reg;
    logic                         empty_reg;
    logic [tpc_pkg::TILE_W-1:0]   tx_reg;
    logic [tpc_pkg::TILE_W-1:0]   ty_reg;
    logic [tpc_pkg::TILE_W-1:0]   tx_next;
    logic [tpc_pkg::TILE_W-1:0]   ty_next;
    logic                         hit_reg;

    logic [tpc_pkg::SHAPE_W-1:0]  map_mem [tpc_pkg::MAP_ENTRIES];
    logic [tpc_pkg::SHAPE_W-1:0]  shape_reg;

    logic signed [tpc_pkg::EXT_W-1:0] x0_c;
    logic signed [tpc_pkg::EXT_W-1:0] y0_c;
    logic signed [tpc_pkg::EXT_W-1:0] xe_c;
    logic signed [tpc_pkg::EXT_W-1:0] ye_c;
    logic signed [tpc_pkg::EXT_W-1:0] xe_raw;
    logic signed [tpc_pkg::EXT_W-1:0] ye_raw;
    logic signed [tpc_pkg::EXT_W-1:0] gw_ext;
    logic signed [tpc_pkg::EXT_W-1:0] gh_ext;
    logic signed [tpc_pkg::EXT_W-1:0] px1_c;
    logic signed [tpc_pkg::EXT_W-1:0] py1_c;

    logic [tpc_pkg::TILE_W-1:0]   tx0;
    logic [tpc_pkg::TILE_W-1:0]   tx1;
    logic [tpc_pkg::TILE_W-1:0]   ty0;
    logic [tpc_pkg::TILE_W-1:0]   ty1;
    logic [tpc_pkg::LIN_W-1:0]    lin_addr;
    logic [tpc_pkg::MAP_ADDR_W-1:0] rd_addr;
    logic [tpc_pkg::ROW_W-1:0]    c0;
    logic [tpc_pkg::ROW_W-1:0]    c1;
    logic [tpc_pkg::ROW_W-1:0]    r0;
    logic [tpc_pkg::ROW_W-1:0]    r1;
    logic [tpc_pkg::MASK_W-1:0]   cols;
    logic                         mask_hit;

    assign in_fields = tpc_pkg::in_data_t'(s_tdata);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_w_reg <= tpc_pkg::GRID_WIDTH_RST;
            grid_h_reg <= tpc_pkg::GRID_HEIGHT_RST;
            stride_reg <= tpc_pkg::TILES_ROW_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tpc_pkg::REG_GRID_WIDTH:  grid_w_reg <= cfg_data;
                tpc_pkg::REG_GRID_HEIGHT: grid_h_reg <= cfg_data;
                tpc_pkg::REG_TILES_ROW:   stride_reg <= cfg_data[tpc_pkg::STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // rectangle capture, on every accepted transfer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rx_reg <= in_fields.rect_x;
            ry_reg <= in_fields.rect_y;
            rw_reg <= in_fields.rect_width;
            rh_reg <= in_fields.rect_height;
        end
    end

    // clip to the grid extent
    always_comb
    begin
        xe_raw = $signed({{(tpc_pkg::EXT_W-tpc_pkg::COORD_W){rx_reg[tpc_pkg::COORD_W-1]}}, rx_reg})
               + $signed({{(tpc_pkg::EXT_W-tpc_pkg::PIX_W){1'b0}}, rw_reg});
        ye_raw = $signed({{(tpc_pkg::EXT_W-tpc_pkg::COORD_W){ry_reg[tpc_pkg::COORD_W-1]}}, ry_reg})
               + $signed({{(tpc_pkg::EXT_W-tpc_pkg::PIX_W){1'b0}}, rh_reg});
        gw_ext = $signed({{(tpc_pkg::EXT_W-tpc_pkg::PIX_W){1'b0}}, grid_w_reg});
        gh_ext = $signed({{(tpc_pkg::EXT_W-tpc_pkg::PIX_W){1'b0}}, grid_h_reg});
        xe_c   = (xe_raw > gw_ext) ? gw_ext : xe_raw;
        ye_c   = (ye_raw > gh_ext) ? gh_ext : ye_raw;
        x0_c   = rx_reg[tpc_pkg::COORD_W-1] ? '0 :
                 $signed({{(tpc_pkg::EXT_W-tpc_pkg::COORD_W){1'b0}}, rx_reg});
        y0_c   = ry_reg[tpc_pkg::COORD_W-1] ? '0 :
                 $signed({{(tpc_pkg::EXT_W-tpc_pkg::COORD_W){1'b0}}, ry_reg});
        px1_c  = xe_c - tpc_pkg::EXT_W'(1);
        py1_c  = ye_c - tpc_pkg::EXT_W'(1);
    end

    assign tx0 = px0_reg[tpc_pkg::PIX_W-1:tpc_pkg::ROW_W];
    assign tx1 = px1_reg[tpc_pkg::PIX_W-1:tpc_pkg::ROW_W];
    assign ty0 = py0_reg[tpc_pkg::PIX_W-1:tpc_pkg::ROW_W];
    assign ty1 = py1_reg[tpc_pkg::PIX_W-1:tpc_pkg::ROW_W];

    // tile walk, row by row of tiles
    always_comb
    begin
        tx_next = tx_reg;
        ty_next = ty_reg;
        if (cmd.clip)
        begin
            tx_next = x0_c[tpc_pkg::PIX_W-1:tpc_pkg::ROW_W];
            ty_next = y0_c[tpc_pkg::PIX_W-1:tpc_pkg::ROW_W];
        end
        else if (cmd.step)
        begin
            if (tx_reg == tx1)
            begin
                tx_next = tx0;
                ty_next = ty_reg + tpc_pkg::TILE_W'(1);
            end
            else
            begin
                tx_next = tx_reg + tpc_pkg::TILE_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clip)
        begin
            empty_reg <= (xe_c <= x0_c) || (ye_c <= y0_c);
            px0_reg   <= x0_c[tpc_pkg::PIX_W-1:0];
            py0_reg   <= y0_c[tpc_pkg::PIX_W-1:0];
            px1_reg   <= px1_c[tpc_pkg::PIX_W-1:0];
            py1_reg   <= py1_c[tpc_pkg::PIX_W-1:0];
        end
        tx_reg <= tx_next;
        ty_reg <= ty_next;
    end

    // map memory, wraps on the entry count
    assign lin_addr = tpc_pkg::LIN_W'(ty_reg) * tpc_pkg::LIN_W'(stride_reg)
                    + tpc_pkg::LIN_W'(tx_reg);
    assign rd_addr  = tpc_pkg::MAP_ADDR_W'(lin_addr);

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            map_mem[in_fields.map_address] <= in_fields.shape_id;
        end
        if (cmd.read)
        begin
            shape_reg <= map_mem[rd_addr];
        end
    end

    // pixel test of one tile
    always_comb
    begin
        c0   = (tx_reg == tx0) ? px0_reg[tpc_pkg::ROW_W-1:0] : '0;
        c1   = (tx_reg == tx1) ? px1_reg[tpc_pkg::ROW_W-1:0] : tpc_pkg::LAST_ROW;
        r0   = (ty_reg == ty0) ? py0_reg[tpc_pkg::ROW_W-1:0] : '0;
        r1   = (ty_reg == ty1) ? py1_reg[tpc_pkg::ROW_W-1:0] : tpc_pkg::LAST_ROW;
        cols = (tpc_pkg::FULL_MASK >> c0) & ~(tpc_pkg::RIGHT_MASK >> c1);
        mask_hit = 1'b0;
        for (int r = 0; r < 16; r++)
        begin
            if (tpc_pkg::ROW_W'(r) >= r0 && tpc_pkg::ROW_W'(r) <= r1 &&
                (tpc_pkg::row_mask(shape_reg, tpc_pkg::ROW_W'(r)) & cols) != '0)
            begin
                mask_hit = 1'b1;
            end
        end
    end

    assign sts.empty     = empty_reg;
    assign sts.tile_hit  = mask_hit;
    assign sts.tile_last = (tx_reg == tx1) && (ty_reg == ty1);

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            hit_reg <= cmd.res_hit;
        end
    end

    assign hit = hit_reg;

endmodule

`default_nettype wire

// ===== rtl/tilemap_pixel_collision_top.sv =====
`default_nettype none

// Tile map pixel collision. A transfer with s_tuser 0 writes one shape number into the
// tile map in the cycle it is accepted and gives no result. A transfer with s_tuser 1 is
// an area query: the rectangle is clipped to the grid, then the covered tiles are read
// from the map one at a time and their row masks tested against the clipped columns and
// rows; the walk stops at the first solid pixel. A query passes the clip state, then
// per tile a registered map read followed by the mask test, up to the first hit or the
// last tile; an empty clip skips the walk. A finished result waits in the output
// register while the next transfer is taken. Map entries are undefined until
// written. The user must write configuration registers (0 grid width, 1 grid height,
// 2 tiles per row) only while idle; the block itself does not enforce this.
module tilemap_pixel_collision_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // map_address[11:0], shape_id[16:12], rect_x[32:17], rect_y[48:33],
    // rect_width[59:49], rect_height[70:60], zero fill[71]
    input  wire logic [tpc_pkg::IN_DATA_W-1:0]       s_tdata,
    // opcode[0]
    input  wire logic [0:0]                          s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // hit[0], zero fill[7:1]
    output logic [tpc_pkg::OUT_DATA_W-1:0]           m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [tpc_pkg::PIX_W-1:0]           cfg_data
);

    tpc_pkg::tpc_cmd_t cmd;
    tpc_pkg::tpc_sts_t sts;
    logic              hit;

    assign cfg_ready = 1'b1;

    tpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_opcode (s_tuser[0]),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tpc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .hit       (hit)
    );

    assign m_tdata = {{(tpc_pkg::OUT_DATA_W-1){1'b0}}, hit};

endmodule

`default_nettype wire

// ===== verif/tpc_collision_checker.sv =====
module tpc_collision_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    // map_address[11:0], shape_id[16:12], rect_x[32:17], rect_y[48:33],
    // rect_width[59:49], rect_height[70:60], zero fill[71]
    input  wire logic [tpc_pkg::IN_DATA_W-1:0] s_tdata,
    // opcode[0]
    input  wire logic [0:0]                    s_tuser,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    // hit[0], zero fill[7:1]
    input  wire logic [tpc_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tpc_pkg::PIX_W-1:0]     cfg_data,
    output int                                 fail_count,
    output int                                 pending
);

    localparam int MAP_DEPTH   = 4096;
    localparam int SHAPE_LIMIT = 26;
    localparam int MASK_SETS   = 22;

    localparam logic [4:0]  SHAPE_EMPTY  = 5'd0;
    localparam logic [4:0]  SHAPE_SOLID  = 5'd1;
    localparam logic [15:0] COLS_FROM    = 16'hFFFF;
    localparam logic [15:0] COLS_PAST    = 16'h7FFF;
    localparam logic [10:0] WIDTH_RESET  = 11'd1024;
    localparam logic [10:0] HEIGHT_RESET = 11'd1024;
    localparam logic [6:0]  STRIDE_RESET = 7'd64;

    // bit 15 is the leftmost pixel column of a tile
    localparam logic [15:0] ROW_MASKS [MASK_SETS][16] = '{
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        '{16'h0001, 16'h0003, 16'h0007, 16'h000F, 16'h001F, 16'h003F, 16'h007F, 16'h00FF,
          16'h01FF, 16'h03FF, 16'h07FF, 16'h0FFF, 16'h1FFF, 16'h3FFF, 16'h7FFF, 16'hFFFF},
        '{16'hFFFF, 16'h7FFF, 16'h3FFF, 16'h1FFF, 16'h0FFF, 16'h07FF, 16'h03FF, 16'h01FF,
          16'h00FF, 16'h007F, 16'h003F, 16'h001F, 16'h000F, 16'h0007, 16'h0003, 16'h0001},
        '{16'h8000, 16'hC000, 16'hE000, 16'hF000, 16'hF800, 16'hFC00, 16'hFE00, 16'hFF00,
          16'hFF80, 16'hFFC0, 16'hFFE0, 16'hFFF0, 16'hFFF8, 16'hFFFC, 16'hFFFE, 16'hFFFF},
        '{16'hFFFF, 16'hFFFE, 16'hFFFC, 16'hFFF8, 16'hFFF0, 16'hFFE0, 16'hFFC0, 16'hFF80,
          16'hFF00, 16'hFE00, 16'hFC00, 16'hF800, 16'hF000, 16'hE000, 16'hC000, 16'h8000},
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          16'h0003, 16'h000F, 16'h003F, 16'h00FF, 16'h03FF, 16'h0FFF, 16'h3FFF, 16'hFFFF},
        '{16'hFFFF, 16'h3FFF, 16'h0FFF, 16'h03FF, 16'h00FF, 16'h003F, 16'h000F, 16'h0003,
          16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          16'hC000, 16'hF000, 16'hFC00, 16'hFF00, 16'hFFC0, 16'hFFF0, 16'hFFFC, 16'hFFFF},
        '{16'hFFFF, 16'hFFFC, 16'hFFF0, 16'hFFC0, 16'hFF00, 16'hFC00, 16'hF000, 16'hC000,
          16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'h0001, 16'h0001, 16'h0003, 16'h0003, 16'h0007, 16'h0007, 16'h000F, 16'h000F,
          16'h001F, 16'h001F, 16'h003F, 16'h003F, 16'h007F, 16'h007F, 16'h00FF, 16'h00FF},
        '{16'h00FF, 16'h00FF, 16'h007F, 16'h007F, 16'h003F, 16'h003F, 16'h001F, 16'h001F,
          16'h000F, 16'h000F, 16'h0007, 16'h0007, 16'h0003, 16'h0003, 16'h0001, 16'h0001},
        '{16'h8000, 16'h8000, 16'hC000, 16'hC000, 16'hE000, 16'hE000, 16'hF000, 16'hF000,
          16'hF800, 16'hF800, 16'hFC00, 16'hFC00, 16'hFE00, 16'hFE00, 16'hFF00, 16'hFF00},
        '{16'hFF00, 16'hFF00, 16'hFE00, 16'hFE00, 16'hFC00, 16'hFC00, 16'hF800, 16'hF800,
          16'hF000, 16'hF000, 16'hE000, 16'hE000, 16'hC000, 16'hC000, 16'h8000, 16'h8000},
        '{16'h0003, 16'h000F, 16'h003F, 16'h00FF, 16'h03FF, 16'h0FFF, 16'h3FFF, 16'hFFFF,
          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          16'hFFFF, 16'h3FFF, 16'h0FFF, 16'h03FF, 16'h00FF, 16'h003F, 16'h000F, 16'h0003},
        '{16'hC000, 16'hF000, 16'hFC00, 16'hFF00, 16'hFFC0, 16'hFFF0, 16'hFFFC, 16'hFFFF,
          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          16'hFFFF, 16'hFFFC, 16'hFFF0, 16'hFFC0, 16'hFF00, 16'hFC00, 16'hF000, 16'hC000},
        '{16'h01FF, 16'h01FF, 16'h03FF, 16'h03FF, 16'h07FF, 16'h07FF, 16'h0FFF, 16'h0FFF,
          16'h1FFF, 16'h1FFF, 16'h3FFF, 16'h3FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF},
        '{16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h3FFF, 16'h3FFF, 16'h1FFF, 16'h1FFF,
          16'h0FFF, 16'h0FFF, 16'h07FF, 16'h07FF, 16'h03FF, 16'h03FF, 16'h01FF, 16'h01FF},
        '{16'hFF80, 16'hFF80, 16'hFFC0, 16'hFFC0, 16'hFFE0, 16'hFFE0, 16'hFFF0, 16'hFFF0,
          16'hFFF8, 16'hFFF8, 16'hFFFC, 16'hFFFC, 16'hFFFE, 16'hFFFE, 16'hFFFF, 16'hFFFF},
        '{16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFE, 16'hFFFC, 16'hFFFC, 16'hFFF8, 16'hFFF8,
          16'hFFF0, 16'hFFF0, 16'hFFE0, 16'hFFE0, 16'hFFC0, 16'hFFC0, 16'hFF80, 16'hFF80}
    };

    logic [4:0]          tile_shape [MAP_DEPTH];
    logic [10:0]         grid_w;
    logic [10:0]         grid_h;
    logic [6:0]          stride;
    logic                hit_expected [$];
    int                  mismatches;
    tpc_pkg::in_data_t   item;
    logic                want;

    function automatic logic [15:0] solid_row(input logic [4:0] shp, input int row);
        if (int'(shp) < SHAPE_LIMIT && int'(shp) < MASK_SETS)
        begin
            return ROW_MASKS[shp][row];
        end
        return '0;
    endfunction

    function automatic logic probe_area(input logic signed [15:0] rx,
                                        input logic signed [15:0] ry,
                                        input logic [10:0] rw,
                                        input logic [10:0] rh);
        int sx, sy, x0, y0, xe, ye;
        int tx0, tx1, ty0, ty1, r0, r1, c0, c1, lin;
        logic [4:0]  shp;
        logic [15:0] cols;
        sx = rx;
        sy = ry;
        x0 = (sx < 0) ? 0 : sx;
        y0 = (sy < 0) ? 0 : sy;
        xe = sx + int'(rw);
        ye = sy + int'(rh);
        if (xe > int'(grid_w))
        begin
            xe = int'(grid_w);
        end
        if (ye > int'(grid_h))
        begin
            ye = int'(grid_h);
        end
        if (xe <= x0 || ye <= y0)
        begin
            return 1'b0;
        end
        tx0 = x0 / 16;
        tx1 = (xe - 1) / 16;
        ty0 = y0 / 16;
        ty1 = (ye - 1) / 16;
        for (int ty = ty0; ty <= ty1; ty++)
        begin
            r0 = (ty == ty0) ? (y0 % 16) : 0;
            r1 = (ty == ty1) ? ((ye - 1) % 16) : 15;
            for (int tx = tx0; tx <= tx1; tx++)
            begin
                lin = (tx + ty * int'(stride)) % MAP_DEPTH;
                shp = tile_shape[lin];
                if (shp == SHAPE_EMPTY)
                begin
                    continue;
                end
                if (shp == SHAPE_SOLID)
                begin
                    return 1'b1;
                end
                c0 = (tx == tx0) ? (x0 % 16) : 0;
                c1 = (tx == tx1) ? ((xe - 1) % 16) : 15;
                cols = (COLS_FROM >> c0) & ~(COLS_PAST >> c1);
                for (int r = r0; r <= r1; r++)
                begin
                    if ((solid_row(shp, r) & cols) != '0)
                    begin
                        return 1'b1;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_w = WIDTH_RESET;
            grid_h = HEIGHT_RESET;
            stride = STRIDE_RESET;
            hit_expected.delete();
            mismatches = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tpc_pkg::REG_GRID_WIDTH:  grid_w = cfg_data;
                    tpc_pkg::REG_GRID_HEIGHT: grid_h = cfg_data;
                    tpc_pkg::REG_TILES_ROW:   stride = cfg_data[6:0];
                    default:                  ;
                endcase
            end
            // results leave before a query in the same edge can add one
            if (m_tvalid && m_tready)
            begin
                if (hit_expected.size() == 0)
                begin
                    $error("hit: expected none, got %0d", m_tdata[0]);
                    mismatches++;
                end
                else
                begin
                    want = hit_expected.pop_front();
                    if (m_tdata[0] !== want)
                    begin
                        $error("hit: expected %0d, got %0d", want, m_tdata[0]);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                item = s_tdata;
                if (s_tuser[0] == tpc_pkg::OP_WRITE)
                begin
                    tile_shape[item.map_address] = item.shape_id;
                end
                else
                begin
                    hit_expected.push_back(probe_area(item.rect_x, item.rect_y,
                                                      item.rect_width, item.rect_height));
                end
            end
            fail_count <= mismatches;
            pending <= hit_expected.size();
        end
    end

endmodule

// ===== verif/tilemap_pixel_collision_top_tb.sv =====
module tilemap_pixel_collision_top_tb;

    localparam int LIMIT_TIME    = 2_000_000_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int FILL_DEPTH    = 1024;
    localparam logic [tpc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [tpc_pkg::IN_DATA_W-1:0] s_tdata;
    logic [0:0]                    s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [tpc_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tpc_pkg::PIX_W-1:0]     cfg_data;
    int                            fail_count;
    int                            pending;
    bit                            calm;
    int                            cur_w;
    int                            cur_h;

    tilemap_pixel_collision_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tpc_collision_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #LIMIT_TIME;
        $display("Verification failed");
        $finish;
    end

    // receiver stalls in bursts
    initial
    begin
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    task automatic push_item(input logic op, input logic [11:0] addr, input logic [4:0] shp,
                             input logic [15:0] rx, input logic [15:0] ry,
                             input logic [10:0] rw, input logic [10:0] rh);
        tpc_pkg::in_data_t d;
        d = '0;
        d.map_address = addr;
        d.shape_id    = shp;
        d.rect_x      = rx;
        d.rect_y      = ry;
        d.rect_width  = rw;
        d.rect_height = rh;
        s_tdata  <= d;
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic write_tile(input logic [11:0] addr, input logic [4:0] shp);
        push_item(tpc_pkg::OP_WRITE, addr, shp, 16'($urandom), 16'($urandom),
                  11'($urandom), 11'($urandom));
    endtask

    task automatic query(input logic [15:0] rx, input logic [15:0] ry,
                         input logic [10:0] rw, input logic [10:0] rh);
        push_item(tpc_pkg::OP_QUERY, 12'($urandom), 5'($urandom), rx, ry, rw, rh);
    endtask

    task automatic sender_gap(input bit gappy);
        if (!calm && gappy && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [tpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tpc_pkg::PIX_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic set_grid(input int w, input int h, input int tiles);
        wait_idle();
        set_reg(tpc_pkg::REG_GRID_WIDTH, w[10:0]);
        set_reg(tpc_pkg::REG_GRID_HEIGHT, h[10:0]);
        set_reg(tpc_pkg::REG_TILES_ROW, tiles[10:0]);
        set_reg(REG_SPARE, 11'($urandom));
        cfg_valid <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    function automatic logic [4:0] pick_shape();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            return 5'd0;
        end
        if (r < 40)
        begin
            return 5'd1;
        end
        if (r < 95)
        begin
            return 5'($urandom_range(2, 25));
        end
        return 5'($urandom_range(26, 31));
    endfunction

    task automatic random_query();
        int          pick;
        int          cx;
        int          cy;
        logic [10:0] rw;
        logic [10:0] rh;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            query(16'($urandom), 16'($urandom), 11'($urandom), 11'($urandom));
        end
        else if (pick < 11)
        begin
            cx = $urandom_range(0, cur_w + 64) - 64;
            cy = $urandom_range(0, cur_h + 64) - 64;
            query(cx[15:0], cy[15:0], 11'($urandom_range(0, 2047)),
                  11'($urandom_range(0, 2047)));
        end
        else
        begin
            cx = $urandom_range(0, cur_w + 32) - 16;
            cy = $urandom_range(0, cur_h + 32) - 16;
            rw = ($urandom_range(0, 9) < 3) ? 11'd1 : 11'($urandom_range(0, 40));
            rh = ($urandom_range(0, 9) < 2) ? 11'd1 : 11'($urandom_range(0, 40));
            query(cx[15:0], cy[15:0], rw, rh);
        end
    endtask

    initial
    begin
        int phase_w [7];
        int phase_h [7];
        int phase_t [7];
        int phase_n [7];
        int tx_top;
        int ty_top;
        bit gappy;

        // every phase grid keeps its linear tile addresses inside the filled part of the map
        phase_w = '{1024, 2047, 0, 160, 40, 300, 1};
        phase_h = '{256, 128, 0, 96, 2047, 120, 1};
        phase_t = '{64, 127, 0, 10, 0, 127, 0};
        phase_n = '{110, 110, 40, 110, 110, 110, 160};
        phase_t[6] = $urandom_range(1, 127);
        phase_w[6] = $urandom_range(1, 2047);
        tx_top = (phase_w[6] - 1) / 16;
        ty_top = (FILL_DEPTH - 1 - tx_top) / phase_t[6];
        if (ty_top > 127)
        begin
            ty_top = 127;
        end
        phase_h[6] = $urandom_range(1, 16 * (ty_top + 1));
        if (phase_h[6] > 2047)
        begin
            phase_h[6] = 2047;
        end

        calm = 1'b0;
        cur_w = 1024;
        cur_h = 1024;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= tpc_pkg::OP_WRITE;
        cfg_valid <= 1'b0;
        cfg_index <= tpc_pkg::REG_GRID_WIDTH;
        cfg_data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_grid(1024, 1024, 64);

        // the filled part of the map gets a shape before any query can read it
        for (int a = 0; a < FILL_DEPTH; a++)
        begin
            write_tile(a[11:0], pick_shape());
            sender_gap(a < 512);
        end

        // hand-picked cases
        write_tile(12'd0, 5'd1);
        query(16'd0, 16'd0, 11'd1, 11'd1);
        write_tile(12'd1, 5'd0);
        query(16'd16, 16'd0, 11'd16, 11'd16);
        write_tile(12'd2, 5'd2);
        query(16'd32, 16'd0, 11'd15, 11'd1);
        query(16'd47, 16'd0, 11'd1, 11'd1);
        write_tile(12'd3, 5'd23);
        query(16'd48, 16'd0, 11'd16, 11'd16);
        write_tile(12'd4, 5'd31);
        query(16'd64, 16'd0, 11'd16, 11'd16);
        query(16'h8000, 16'h8000, 11'd2047, 11'd2047);
        query(16'h7FFF, 16'h7FFF, 11'd2047, 11'd2047);
        query(16'd100, 16'd100, 11'd0, 11'd5);
        query(16'd100, 16'd100, 11'd5, 11'd0);
        query(-16'sd5, -16'sd5, 11'd6, 11'd6);
        query(16'd0, 16'd0, 11'd2047, 11'd2047);
        query(16'd0, 16'd20, 11'd1024, 11'd1);
        write_tile(12'd4095, 5'd25);
        query(16'd1008, 16'd1008, 11'd16, 11'd16);
        write_tile(12'd4095, 5'd21);
        query(16'd1008, 16'd1008, 11'd16, 11'd16);
        query(16'd1023, 16'd1023, 11'd1, 11'd1);

        // tile address past the map end wraps round to entry 95
        set_grid(2047, 2047, 127);
        write_tile(12'd95, 5'd1);
        query(16'd2040, 16'd520, 11'd1, 11'd1);
        write_tile(12'd95, 5'd0);
        query(16'd2040, 16'd520, 11'd1, 11'd1);

        for (int p = 0; p < 7; p++)
        begin
            set_grid(phase_w[p], phase_h[p], phase_t[p]);
            calm = (p == 6);
            for (int k = 0; k < phase_n[p]; k++)
            begin
                gappy = ((k / 40) % 2) == 0;
                if ($urandom_range(0, 3) == 0)
                begin
                    write_tile(12'($urandom_range(0, FILL_DEPTH - 1)), pick_shape());
                end
                else
                begin
                    random_query();
                end
                sender_gap(gappy);
            end
        end

        wait_idle();
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tpc_pkg.sv
rtl/tpc_ctrl.sv
rtl/tpc_dp.sv
rtl/tilemap_pixel_collision_top.sv
verif/tpc_collision_checker.sv
verif/tilemap_pixel_collision_top_tb.sv
